// ===== rtl/core/ltdn_pkg.sv =====
// ----------------------------------------------------------------------------
// ltdn_pkg
// Shared types and constants for the landmark table with dedupe and
// nearest-landmark search.
// ----------------------------------------------------------------------------
`default_nettype none

package ltdn_pkg;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 16;
  localparam int R2_W     = 2 * RADIUS_W;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int IDX_W    = 8;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd1280;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } req_t;

  typedef struct packed {
    logic                      added;
    logic                      is_duplicate;
    logic                      map_full;
    logic                      map_empty;
    logic [IDX_W-1:0]          nearest_index;
    logic signed [COORD_W-1:0] nearest_x;
    logic signed [COORD_W-1:0] nearest_y;
  } rsp_t;

  typedef logic [RADIUS_W-1:0] cfg_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic rsp_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/ltdn_chan_if.sv =====
// ----------------------------------------------------------------------------
// ltdn_chan_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface ltdn_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ltdn_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltdn_ctrl
// Sequencer: takes an item, walks the table addresses, waits for the
// distance pipeline to drain, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ltdn_ctrl #(
  parameter int CW = 9
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire ltdn_pkg::sts_t sts,
  input  wire logic [CW-1:0]  count,
  output ltdn_pkg::cmd_t      cmd,
  output logic [CW-1:0]       addr
);
  import ltdn_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] addr_next;

  always_comb begin
    state_next = state;
    addr_next  = addr;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          addr_next  = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr == count) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
          addr_next = addr + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.rsp_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ltdn_dp.sv =====
// ----------------------------------------------------------------------------
// ltdn_dp
// Datapath: landmark memory, radius register, three-stage squared distance
// pipeline, dedupe and nearest accumulators, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ltdn_dp #(
  parameter int CAPACITY = 256,
  parameter int CW       = 9,
  parameter int AW       = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ltdn_pkg::cmd_t cmd,
  input  wire logic [CW-1:0]  addr,
  input  wire ltdn_pkg::req_t req_data,
  input  wire logic           cfg_valid,
  input  wire ltdn_pkg::cfg_t cfg_data,
  input  wire logic           rsp_ready,
  output logic                rsp_valid,
  output ltdn_pkg::rsp_t      rsp_data,
  output ltdn_pkg::sts_t      sts,
  output logic [CW-1:0]       count
);
  import ltdn_pkg::*;

  logic [2*COORD_W-1:0]      mem [CAPACITY];
  logic [2*COORD_W-1:0]      rd;

  logic [RADIUS_W-1:0]       radius;
  logic [R2_W-1:0]           r2;

  logic                      kind_q;
  logic signed [COORD_W-1:0] px_q;
  logic signed [COORD_W-1:0] py_q;

  logic                      v1;
  logic                      v2;
  logic                      v3;
  logic [AW-1:0]             idx1;
  logic [AW-1:0]             idx2;
  logic [AW-1:0]             idx3;
  logic signed [COORD_W-1:0] x2;
  logic signed [COORD_W-1:0] y2;
  logic signed [COORD_W-1:0] x3;
  logic signed [COORD_W-1:0] y3;
  logic [COORD_W-1:0]        dx2;
  logic [COORD_W-1:0]        dy2;
  logic [SQ_W-1:0]           sx3;
  logic [SQ_W-1:0]           sy3;

  logic signed [COORD_W:0]   diff_x;
  logic signed [COORD_W:0]   diff_y;
  logic signed [COORD_W:0]   abs_x;
  logic signed [COORD_W:0]   abs_y;
  logic signed [COORD_W-1:0] rd_x;
  logic signed [COORD_W-1:0] rd_y;
  logic [DIST_W-1:0]         dsq;

  logic                      dup;
  logic                      have_best;
  logic [DIST_W-1:0]         best_d;
  logic [AW-1:0]             best_idx;
  logic signed [COORD_W-1:0] best_x;
  logic signed [COORD_W-1:0] best_y;

  logic                      full;
  logic                      wr_en;
  rsp_t                      rsp_next;

  // config and squared radius
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    r2 <= R2_W'(radius) * R2_W'(radius);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_q <= req_data.kind;
      px_q   <= req_data.pos_x;
      py_q   <= req_data.pos_y;
    end
  end

  // landmark memory
  assign full  = (count == CW'(CAPACITY));
  assign wr_en = cmd.finish && (kind_q == KIND_INSERT) && !dup && !full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= {px_q, py_q};
    end
    if (cmd.issue) begin
      rd <= mem[addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + 1'b1;
    end
  end

  // distance pipeline
  assign rd_x   = rd[2*COORD_W-1:COORD_W];
  assign rd_y   = rd[COORD_W-1:0];
  assign diff_x = (COORD_W+1)'(rd_x) - (COORD_W+1)'(px_q);
  assign diff_y = (COORD_W+1)'(rd_y) - (COORD_W+1)'(py_q);
  assign abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
  assign abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;
  assign dsq    = DIST_W'(sx3) + DIST_W'(sy3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= addr[AW-1:0];
    idx2 <= idx1;
    x2   <= rd_x;
    y2   <= rd_y;
    dx2  <= abs_x[COORD_W-1:0];
    dy2  <= abs_y[COORD_W-1:0];
    idx3 <= idx2;
    x3   <= x2;
    y3   <= y2;
    sx3  <= SQ_W'(dx2) * SQ_W'(dx2);
    sy3  <= SQ_W'(dy2) * SQ_W'(dy2);
  end

  // dedupe and nearest accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      dup       <= 1'b0;
      have_best <= 1'b0;
    end else if (v3) begin
      if (dsq < DIST_W'(r2)) begin
        dup <= 1'b1;
      end
      if (!have_best || dsq < best_d) begin
        have_best <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && (!have_best || dsq < best_d)) begin
      best_d   <= dsq;
      best_idx <= idx3;
      best_x   <= x3;
      best_y   <= y3;
    end
  end

  // result register
  always_comb begin
    rsp_next = '0;
    if (kind_q == KIND_INSERT) begin
      if (dup) begin
        rsp_next.is_duplicate = 1'b1;
      end else if (full) begin
        rsp_next.map_full = 1'b1;
      end else begin
        rsp_next.added = 1'b1;
      end
    end else if (count == '0) begin
      rsp_next.map_empty = 1'b1;
    end else begin
      rsp_next.nearest_index = IDX_W'(best_idx);
      rsp_next.nearest_x     = best_x;
      rsp_next.nearest_y     = best_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_data <= rsp_next;
    end
  end

  assign sts.pipe_busy = v1 | v2 | v3;
  assign sts.rsp_free  = !rsp_valid || rsp_ready;

endmodule

`default_nettype wire

// ===== rtl/core/landmark_table_dedupe_nearest.sv =====
// ----------------------------------------------------------------------------
// landmark_table_dedupe_nearest
// Table of 2D landmarks with radius dedupe on insert and nearest search.
//
// req carries kind, pos_x, pos_y (signed Q15.8). kind insert appends the
// position unless a stored landmark lies strictly inside match_radius
// (is_duplicate) or the table is full (map_full). kind query returns the
// nearest stored landmark, lowest index on ties, or map_empty.
// cfg carries match_radius (Q8.8); write it only while the block is idle.
// rsp carries one beat per req beat.
// Each item scans every stored entry through the single read port of the
// landmark memory, one entry a cycle, then a three-stage distance pipeline
// drains and the result goes to the rsp register; on an empty table the
// scan issues no reads. Once the result is registered the sequencer is idle
// again and can take the next req beat.
// One item is in work at a time; req is taken again while a finished
// result waits in the rsp register, and a stalled rsp holds the next
// result in the sequencer until the register frees.
// Reset empties the table and sets match_radius to 5.0 m; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module landmark_table_dedupe_nearest #(
  parameter int CAPACITY = 256
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ltdn_chan_if.sink   req,
  ltdn_chan_if.source rsp,
  ltdn_chan_if.sink   cfg
);
  import ltdn_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] addr;
  logic [CW-1:0] count;

  assign cfg.ready = 1'b1;

  ltdn_ctrl #(
    .CW (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .count     (count),
    .cmd       (cmd),
    .addr      (addr)
  );

  ltdn_dp #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .AW       (AW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr      (addr),
    .req_data  (req.data),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .rsp_data  (rsp.data),
    .sts       (sts),
    .count     (count)
  );

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> $onehot0({rsp.data.added, rsp.data.is_duplicate,
                            rsp.data.map_full, rsp.data.map_empty}))
    else $error("more than one status flag in a response");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("landmark count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (rsp.valid && rsp.data.added && count == $past(count) + 1'b1))
    else $error("landmark count moved without an added response");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> addr < count)
    else $error("table read beyond stored entries");

endmodule

`default_nettype wire

// ===== dv/landmark_table_dedupe_nearest_test.sv =====
// ----------------------------------------------------------------------------
// landmark_table_dedupe_nearest_test
// Self-checking bench for the landmark table. Insert and query beats go in on
// req with random gaps while rsp is stalled at random. A scoreboard keeps its
// own copy of the table and radius and checks every rsp beat field by field.
// The run covers several match radius settings, a full table and ties.
// ----------------------------------------------------------------------------
module landmark_table_dedupe_nearest_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ltdn_pkg::*;

  localparam int     DEPTH        = 256;
  localparam int     PHASES       = 7;
  localparam int     RANDOM_ITEMS = 1680;
  localparam int     IDLE_PCT     = 29;
  localparam int     DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT  = 8000000;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MIN = coord_t'(24'h800000);
  localparam coord_t COORD_MAX = coord_t'(24'h7fffff);

  class landmark_book;
    coord_t      xs[DEPTH];
    coord_t      ys[DEPTH];
    int unsigned count;
    cfg_t        radius;
    rsp_t        awaited[$];
    int          mismatches;
    int          n_in, n_added, n_dup, n_full, n_query, n_empty;

    function new();
      count = 0;
      radius = RADIUS_RESET;
      mismatches = 0;
      n_in = 0;
      n_added = 0;
      n_dup = 0;
      n_full = 0;
      n_query = 0;
      n_empty = 0;
    endfunction

    function logic [DIST_W-1:0] dist_sq(coord_t ax, coord_t ay, coord_t bx, coord_t by);
      longint dx, dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return DIST_W'(dx * dx + dy * dy);
    endfunction

    function rsp_t resolve(req_t r);
      rsp_t              o;
      logic [DIST_W-1:0] r2, d, best_d;
      int unsigned       best;
      bit                dup;
      o = '0;
      if (r.kind == KIND_INSERT) begin
        r2 = DIST_W'(radius) * DIST_W'(radius);
        dup = 1'b0;
        for (int i = 0; i < count && !dup; i++) begin
          if (dist_sq(r.pos_x, r.pos_y, xs[i], ys[i]) < r2) dup = 1'b1;
        end
        if (dup) begin
          o.is_duplicate = 1'b1;
          n_dup++;
        end else if (count >= DEPTH) begin
          o.map_full = 1'b1;
          n_full++;
        end else begin
          xs[count] = r.pos_x;
          ys[count] = r.pos_y;
          count++;
          o.added = 1'b1;
          n_added++;
        end
      end else begin
        n_query++;
        if (count == 0) begin
          o.map_empty = 1'b1;
          n_empty++;
        end else begin
          best = 0;
          best_d = dist_sq(xs[0], ys[0], r.pos_x, r.pos_y);
          for (int i = 1; i < count; i++) begin
            d = dist_sq(xs[i], ys[i], r.pos_x, r.pos_y);
            if (d < best_d) begin
              best_d = d;
              best = i;
            end
          end
          o.nearest_index = IDX_W'(best);
          o.nearest_x = xs[best];
          o.nearest_y = ys[best];
        end
      end
      return o;
    endfunction

    function void note_request(req_t r);
      n_in++;
      awaited = {awaited, resolve(r)};
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] ERROR %s", $realtime, msg);
    endtask

    task check_response(rsp_t got);
      rsp_t  want;
      string bad;
      if (awaited.size() == 0) begin
        report($sformatf("rsp beat with nothing pending: %h", got));
        return;
      end
      want = awaited.pop_front();
      bad = "";
      if (got.added !== want.added)
        bad = {bad, $sformatf(" added %0b/%0b", got.added, want.added)};
      if (got.is_duplicate !== want.is_duplicate)
        bad = {bad, $sformatf(" is_duplicate %0b/%0b", got.is_duplicate, want.is_duplicate)};
      if (got.map_full !== want.map_full)
        bad = {bad, $sformatf(" map_full %0b/%0b", got.map_full, want.map_full)};
      if (got.map_empty !== want.map_empty)
        bad = {bad, $sformatf(" map_empty %0b/%0b", got.map_empty, want.map_empty)};
      if (got.nearest_index !== want.nearest_index)
        bad = {bad, $sformatf(" nearest_index %0d/%0d", got.nearest_index, want.nearest_index)};
      if (got.nearest_x !== want.nearest_x)
        bad = {bad, $sformatf(" nearest_x %0d/%0d", got.nearest_x, want.nearest_x)};
      if (got.nearest_y !== want.nearest_y)
        bad = {bad, $sformatf(" nearest_y %0d/%0d", got.nearest_y, want.nearest_y)};
      if (bad != "") report({"rsp beat field error (got/want):", bad});
    endtask
  endclass

  logic         clk;
  logic         rst = 1'b1;
  bit           calm = 1'b0;
  longint       cycles;
  landmark_book sb;

  ltdn_chan_if #(.T(req_t)) req_if ();
  ltdn_chan_if #(.T(rsp_t)) rsp_if ();
  ltdn_chan_if #(.T(cfg_t)) cfg_if ();

  landmark_table_dedupe_nearest #(.CAPACITY(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
  end

  function automatic req_t beat_of(logic kind, coord_t x, coord_t y);
    req_t r;
    r.kind = kind;
    r.pos_x = x;
    r.pos_y = y;
    return r;
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom());
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return coord_t'(-1);
      3: return coord_t'(1);
      default: return coord_t'(0);
    endcase
  endfunction

  function automatic coord_t near_coord(coord_t base, int span);
    int off;
    off = int'($urandom_range(0, 2 * span)) - span;
    return base + coord_t'(off);
  endfunction

  function automatic coord_t cluster_coord();
    return coord_t'(int'($urandom_range(0, 16)) - 8);
  endfunction

  // half the picks place the position around stored landmarks so that dedupe and ties get hit
  function automatic req_t next_item();
    req_t r;
    int   pick, span, a, b;
    pick = $urandom_range(0, 99);
    span = 2 * int'(sb.radius) + 2;
    a = 0;
    b = 0;
    if (sb.count != 0) begin
      a = $urandom_range(0, sb.count - 1);
      b = $urandom_range(0, sb.count - 1);
    end
    r = beat_of((pick < 55) ? KIND_INSERT : KIND_QUERY, any_coord(), any_coord());
    if ((pick >= 20 && pick < 40) || (pick >= 55 && pick < 75)) begin
      if (sb.count != 0) begin
        r.pos_x = near_coord(sb.xs[a], span);
        r.pos_y = near_coord(sb.ys[a], span);
      end
    end else if (pick >= 40 && pick < 45) begin
      if (sb.count != 0) begin
        r.pos_x = sb.xs[a];
        r.pos_y = sb.ys[a];
      end
    end else if (pick >= 85 && pick < 90) begin
      if (sb.count != 0) begin
        r.pos_x = coord_t'((longint'(sb.xs[a]) + longint'(sb.xs[b])) >>> 1);
        r.pos_y = coord_t'((longint'(sb.ys[a]) + longint'(sb.ys[b])) >>> 1);
      end
    end else if ((pick >= 45 && pick < 50) || (pick >= 90 && pick < 95)) begin
      r.pos_x = cluster_coord();
      r.pos_y = cluster_coord();
    end else if ((pick >= 50 && pick < 55) || pick >= 95) begin
      r.pos_x = extreme_coord();
      r.pos_y = extreme_coord();
    end
    return r;
  endfunction

  task automatic send_request(req_t r);
    if (!calm && $urandom_range(0, 24) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 280)) @(negedge clk);
    end
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_radius(cfg_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.radius = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run timed out after %0d cycles", cycles);
    $display("landmark_table_dedupe_nearest: mismatch");
    $finish;
  end

  initial begin
    cfg_t radii[PHASES];
    sb = new();
    req_if.valid = 1'b0;
    req_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    radii[0] = 16'd1;
    radii[1] = 16'hffff;
    radii[2] = cfg_t'($urandom());
    radii[3] = 16'd0;
    radii[4] = RADIUS_RESET;
    radii[5] = cfg_t'($urandom_range(0, 4095));
    radii[6] = 16'hfffe;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset radius: empty query, corners, strict radius edge, ties
    send_request(beat_of(KIND_QUERY, 0, 0));
    send_request(beat_of(KIND_INSERT, COORD_MIN, COORD_MIN));
    send_request(beat_of(KIND_INSERT, COORD_MAX, COORD_MAX));
    send_request(beat_of(KIND_INSERT, COORD_MAX, COORD_MIN));
    send_request(beat_of(KIND_INSERT, COORD_MIN, COORD_MAX));
    send_request(beat_of(KIND_QUERY, COORD_MAX, COORD_MAX));
    send_request(beat_of(KIND_QUERY, 0, 0));
    send_request(beat_of(KIND_INSERT, 0, 0));
    send_request(beat_of(KIND_INSERT, 100, -100));
    send_request(beat_of(KIND_INSERT, 1280, 0));
    send_request(beat_of(KIND_INSERT, 0, -1279));
    send_request(beat_of(KIND_QUERY, 640, 0));
    send_request(beat_of(KIND_QUERY, 1280, 0));
    send_request(beat_of(KIND_INSERT, -1, -1));
    send_request(beat_of(KIND_QUERY, COORD_MIN, COORD_MIN));
    drain();

    // zero radius never matches, so repeats are stored
    write_radius(16'd0);
    send_request(beat_of(KIND_INSERT, 5, 5));
    send_request(beat_of(KIND_INSERT, 5, 5));
    send_request(beat_of(KIND_QUERY, 5, 5));
    send_request(beat_of(KIND_INSERT, 0, 0));
    send_request(beat_of(KIND_QUERY, 0, 1));
    drain();

    write_radius(16'hffff);
    send_request(beat_of(KIND_INSERT, 0, 65534));
    send_request(beat_of(KIND_INSERT, -65535, 0));
    send_request(beat_of(KIND_QUERY, COORD_MIN, 0));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_radius(radii[p]);
      calm = (p == 2);
      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) send_request(next_item());
    end
    drain();
    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d req beats: %0d stored, %0d duplicates, %0d dropped on full table",
             sb.n_in, sb.n_added, sb.n_dup, sb.n_full);
    $display("%0d nearest searches (%0d on empty table), %0d radius settings, %0d entries held",
             sb.n_query, sb.n_empty, PHASES + 2, sb.count);
    if (sb.mismatches == 0) begin
      $display("landmark_table_dedupe_nearest: match");
    end else begin
      $display("%0d rsp beats failed", sb.mismatches);
      $display("landmark_table_dedupe_nearest: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ltdn_pkg.sv
rtl/core/ltdn_chan_if.sv
rtl/core/ltdn_ctrl.sv
rtl/core/ltdn_dp.sv
rtl/core/landmark_table_dedupe_nearest.sv
dv/landmark_table_dedupe_nearest_test.sv
